// File: sv/assert_macros.svh
// Assertion helpers for the triangle box checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check that an implication holds in the cycle after its trigger.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: sv/tbo_pkg.sv
package tbo_pkg;

    localparam int NUM_REGS = 6;
    localparam int ADDR_BITS = 5;

    typedef enum logic [2:0] {
        REG_LOW_X  = 3'd0,
        REG_LOW_Y  = 3'd1,
        REG_LOW_Z  = 3'd2,
        REG_HIGH_X = 3'd3,
        REG_HIGH_Y = 3'd4,
        REG_HIGH_Z = 3'd5
    } reg_idx_t;

    // Pipeline handshake between stages.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// File: sv/tbo_axis_test.sv
// One separating-axis test over three registered stages.
// Stage 1: partial products of the axis, split into a low and a high slice,
// with each vertex coordinate and each box half-size.
// Stage 2: sums. Stage 3: compare against the box radius.
module tbo_axis_test #(
    parameter int AW = 58,
    parameter int VW = 27,
    parameter int HW = 26
) (
    input  logic                 aclk,
    input  logic                 adv,
    input  logic signed [AW-1:0] ax [3],
    input  logic signed [VW-1:0] v  [3][3],
    input  logic signed [HW-1:0] h  [3],
    output logic                 sep_reg
);
    localparam int LB  = (AW + 1) / 2;
    localparam int HB  = AW - LB;
    localparam int MB  = AW + 1 - LB;
    localparam int PLW = LB + 1 + VW;
    localparam int PHW = HB + VW;
    localparam int RLW = LB + 1 + HW;
    localparam int RHW = MB + 1 + HW;
    localparam int SW  = AW + ((VW > HW) ? VW : HW) + 3;

    logic signed [LB:0]    ax_lo [3];
    logic signed [HB-1:0]  ax_hi [3];
    logic [AW:0]           aabs [3];
    logic signed [LB:0]    abs_lo [3];
    logic signed [MB:0]    abs_hi [3];
    logic signed [PLW-1:0] plo_reg [3][3];
    logic signed [PHW-1:0] phi_reg [3][3];
    logic signed [RLW-1:0] rlo_reg [3];
    logic signed [RHW-1:0] rhi_reg [3];
    logic signed [SW-1:0]  p_reg [3];
    logic signed [SW-1:0]  r_reg;

    // axis = ax_hi * 2^LB + ax_lo, with the low slice taken as unsigned
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ax_lo[k]  = signed'({1'b0, ax[k][LB-1:0]});
            ax_hi[k]  = ax[k][AW-1:LB];
            aabs[k]   = ax[k][AW-1] ? -{1'b1, ax[k]} : {1'b0, ax[k]};
            abs_lo[k] = signed'({1'b0, aabs[k][LB-1:0]});
            abs_hi[k] = signed'({1'b0, aabs[k][AW:LB]});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    plo_reg[i][k] <= PLW'(ax_lo[k]) * PLW'(v[i][k]);
                    phi_reg[i][k] <= PHW'(ax_hi[k]) * PHW'(v[i][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                rlo_reg[k] <= RLW'(abs_lo[k]) * RLW'(h[k]);
                rhi_reg[k] <= RHW'(abs_hi[k]) * RHW'(h[k]);
            end
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= ((SW'(phi_reg[i][0]) + SW'(phi_reg[i][1])
                            + SW'(phi_reg[i][2])) <<< LB)
                          + SW'(plo_reg[i][0]) + SW'(plo_reg[i][1]) + SW'(plo_reg[i][2]);
            end
            r_reg <= ((SW'(rhi_reg[0]) + SW'(rhi_reg[1]) + SW'(rhi_reg[2])) <<< LB)
                   + SW'(rlo_reg[0]) + SW'(rlo_reg[1]) + SW'(rlo_reg[2]);
            sep_reg <= ((p_reg[0] > r_reg) && (p_reg[1] > r_reg) && (p_reg[2] > r_reg))
                    || ((p_reg[0] < -r_reg) && (p_reg[1] < -r_reg) && (p_reg[2] < -r_reg));
        end
    end
endmodule

// File: sv/tbo_front.sv
// Relative coordinates, edges, and the triangle normal over four stages.
module tbo_front #(
    parameter int CB = 24
) (
    input  logic                   aclk,
    input  logic                   adv,
    input  logic signed [CB-1:0]   vin [3][3],
    input  logic signed [CB-1:0]   lo  [3],
    input  logic signed [CB-1:0]   hi  [3],
    output logic signed [2*CB+9:0] n_reg  [3],
    output logic signed [CB+2:0]   v3_reg [3][3],
    output logic signed [CB+1:0]   h3_reg [3],
    output logic signed [CB+3:0]   e3_reg [3][3]
);
    localparam int VW = CB + 3;
    localparam int EW = CB + 4;
    localparam int HW = CB + 2;
    localparam int NW = 2 * CB + 10;

    logic signed [VW-1:0]   v_reg  [3][3];
    logic signed [VW-1:0]   v1_reg [3][3];
    logic signed [VW-1:0]   v2_reg [3][3];
    logic signed [HW-1:0]   h_reg  [3];
    logic signed [HW-1:0]   h1_reg [3];
    logic signed [HW-1:0]   h2_reg [3];
    logic signed [EW-1:0]   e_reg  [3][3];
    logic signed [EW-1:0]   e2_reg [3][3];
    logic signed [2*EW-1:0] m_reg [3][2];
    logic signed [NW-1:0]   nn [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nn[k] = NW'(m_reg[k][0]) - NW'(m_reg[k][1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    v_reg[i][k] <= (VW'(vin[i][k]) <<< 1) - VW'(lo[k]) - VW'(hi[k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                h_reg[k] <= HW'(hi[k]) - HW'(lo[k]);
            end
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    e_reg[i][k] <= EW'(v_reg[(i+1)%3][k]) - EW'(v_reg[i][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                m_reg[k][0] <= (2*EW)'(e_reg[0][(k+1)%3]) * (2*EW)'(e_reg[1][(k+2)%3]);
                m_reg[k][1] <= (2*EW)'(e_reg[0][(k+2)%3]) * (2*EW)'(e_reg[1][(k+1)%3]);
                n_reg[k]    <= nn[k];
            end
            // Delay v, h and e so they land with the normal.
            v1_reg <= v_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            h1_reg <= h_reg;
            h2_reg <= h1_reg;
            h3_reg <= h2_reg;
            e2_reg <= e_reg;
            e3_reg <= e2_reg;
        end
    end
endmodule

// File: sv/triangle_box_overlap.sv
// Triangle versus box overlap by the separating axis test over 13 axes. One
// triangle is accepted every clock unless the output stalls; the result passes
// through eight register stages (four front-end stages for relative
// coordinates, edges, edge products and the normal, then three stages per
// axis test and the output register). All 13 axis tests run in parallel
// lanes. A stalled output halts the whole pipeline; tready follows the output side.
module triangle_box_overlap #(
    parameter int COORD_BITS = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // vert_a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // overlaps
    output logic [7:0]                m_tdata,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tbo_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    localparam int CB = COORD_BITS;
    localparam int VW = CB + 3;
    localparam int EW = CB + 4;
    localparam int HW = CB + 2;
    localparam int NW = 2 * CB + 10;
    localparam int DEPTH = 8;

    logic signed [CB-1:0] box_reg [6];
    logic [DEPTH-1:0] vld_reg;
    logic adv;

    assign pready = 1'b1;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) box_reg[i] <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[tbo_pkg::ADDR_BITS-1:2] < 3'(tbo_pkg::NUM_REGS))
                box_reg[paddr[tbo_pkg::ADDR_BITS-1:2]] <= pwdata[CB-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[tbo_pkg::ADDR_BITS-1:2] < 3'(tbo_pkg::NUM_REGS))
            prdata = 32'(signed'(box_reg[paddr[tbo_pkg::ADDR_BITS-1:2]]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
    end

    logic signed [CB-1:0] vin [3][3];
    logic signed [CB-1:0] lo [3];
    logic signed [CB-1:0] hi [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) vin[i][k] = s_tdata[(3*i+k)*CB +: CB];
            lo[i] = box_reg[i];
            hi[i] = box_reg[i+3];
        end
    end

    logic signed [NW-1:0] n_reg [3];
    logic signed [VW-1:0] v3_reg [3][3];
    logic signed [HW-1:0] h3_reg [3];
    logic signed [EW-1:0] e3_reg [3][3];

    tbo_front #(.CB(CB)) u_front (
        .aclk(aclk), .adv(adv), .vin(vin), .lo(lo), .hi(hi),
        .n_reg(n_reg), .v3_reg(v3_reg), .h3_reg(h3_reg), .e3_reg(e3_reg)
    );

    // Axes: lanes 0..2 box axes, 3 normal, 4..12 unit cross edge.
    logic signed [1:0]  ax_box [3][3];
    logic signed [EW:0] ax_crs [9][3];
    always_comb begin
        for (int a = 0; a < 3; a++)
            for (int k = 0; k < 3; k++) ax_box[a][k] = (a == k) ? 2'sd1 : 2'sd0;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                ax_crs[3*k+i][k]       = '0;
                ax_crs[3*k+i][(k+1)%3] = -(EW+1)'(e3_reg[i][(k+2)%3]);
                ax_crs[3*k+i][(k+2)%3] = (EW+1)'(e3_reg[i][(k+1)%3]);
            end
        end
    end

    logic [12:0] sep;
    for (genvar a = 0; a < 3; a++) begin : g_box
        tbo_axis_test #(.AW(2), .VW(VW), .HW(HW)) u_axis (
            .aclk(aclk), .adv(adv), .ax(ax_box[a]), .v(v3_reg), .h(h3_reg),
            .sep_reg(sep[a])
        );
    end

    tbo_axis_test #(.AW(NW), .VW(VW), .HW(HW)) u_norm (
        .aclk(aclk), .adv(adv), .ax(n_reg), .v(v3_reg), .h(h3_reg),
        .sep_reg(sep[3])
    );

    for (genvar a = 0; a < 9; a++) begin : g_cross
        tbo_axis_test #(.AW(EW+1), .VW(VW), .HW(HW)) u_axis (
            .aclk(aclk), .adv(adv), .ax(ax_crs[a]), .v(v3_reg), .h(h3_reg),
            .sep_reg(sep[4+a])
        );
    end

    logic ovl_reg;
    always_ff @(posedge aclk) begin
        if (adv) ovl_reg <= ~|sep;
    end
    assign m_tdata = {7'b0, ovl_reg};
endmodule

// File: sv/tbo_checker.sv
`include "assert_macros.svh"
module tbo_sva (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [7:0] m_tdata
);
    `CHK_IMPL(a_ready_follows, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `CHK_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CHK_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:1] == 7'd0)
endmodule

bind triangle_box_overlap tbo_sva u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
